// ===== rtl/core/csrspmv_pkg.sv =====
// ----------------------------------------------------------------------------
// csrspmv_pkg
// shared types and constants of the csr sparse matrix-vector row accumulator
// ----------------------------------------------------------------------------
`default_nettype none

package csrspmv_pkg;

   // field widths
   localparam int POS_W     = 10;
   localparam int VALUE_W   = 32;
   localparam int ROW_W     = 16;
   localparam int VLEN_W    = 11;
   localparam int PROD_W    = 2 * VALUE_W;
   localparam int FRAC_W    = 16;
   // wide enough to hold any position and any store depth in range
   localparam int EXT_W     = 17;

   localparam int VECTOR_DEPTH_DEFAULT = 1024;
   localparam logic [VLEN_W-1:0] VLEN_RESET = VLEN_W'(1024);

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef enum logic [1:0] {
      KIND_LOAD    = 2'd0,
      KIND_NONZERO = 2'd1,
      KIND_CLOSE   = 2'd2,
      KIND_RESTART = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      OP_NONE    = 3'd0,
      OP_WRITE   = 3'd1,
      OP_MAC     = 3'd2,
      OP_BAD     = 3'd3,
      OP_CLOSE   = 3'd4,
      OP_RESTART = 3'd5
   } cmd_op_type;

   typedef struct packed {
      req_kind_type              req_type;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] operand_value;
      logic                      row_last;
   } req_payload_type;

   typedef struct packed {
      logic [ROW_W-1:0]          row_number;
      logic signed [VALUE_W-1:0] row_sum;
      logic                      saturated;
      logic                      bad_column;
   } rsp_payload_type;

   typedef logic [VLEN_W-1:0] csr_payload_type;

   typedef struct packed {
      cmd_op_type                op;
      logic [POS_W-1:0]          addr;
      logic signed [VALUE_W-1:0] value;
      logic                      emit;
   } cmd_type;

   typedef struct packed {
      logic              empty;
      logic              full;
      logic [QCNT_W-1:0] count;
   } q_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/csrspmv_chan_if.sv =====
// ----------------------------------------------------------------------------
// csrspmv_chan_if
// valid/ready channel carrying one payload per request
// ----------------------------------------------------------------------------
`default_nettype none

interface csrspmv_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ===== rtl/core/csrspmv_front.sv =====
// ----------------------------------------------------------------------------
// csrspmv_front
// takes requests, checks columns against the vector length and store depth, forms commands
// ----------------------------------------------------------------------------
`default_nettype none

module csrspmv_front #(
   parameter int VECTOR_DEPTH = csrspmv_pkg::VECTOR_DEPTH_DEFAULT
) (
   input  wire                        clock,
   input  wire                        reset,
   csrspmv_chan_if.sink               req_if,
   csrspmv_chan_if.sink               csr_if,
   output logic                       push,
   output csrspmv_pkg::cmd_type       push_data,
   input  csrspmv_pkg::q_status_type  q_status
);

   import csrspmv_pkg::*;

   localparam logic [EXT_W-1:0] DepthLimit = EXT_W'(VECTOR_DEPTH);

   logic [VLEN_W-1:0] vlen_ff;
   logic [VLEN_W-1:0] vlen_in;
   logic [EXT_W-1:0]  pos_ext;
   logic              col_bad;
   req_payload_type   req;

   // vector length register, writes always taken
   assign csr_if.ready = 1'b1;

   always_comb begin
      vlen_in = vlen_ff;
      if (csr_if.valid) begin
         vlen_in = csr_if.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vlen_ff <= VLEN_RESET;
      end else begin
         vlen_ff <= vlen_in;
      end
   end

   assign req          = req_if.payload;
   assign req_if.ready = !q_status.full;
   assign push         = req_if.valid && !q_status.full;
   assign pos_ext      = EXT_W'(req.position);
   assign col_bad      = (VLEN_W'(req.position) >= vlen_ff) || (pos_ext >= DepthLimit);

   always_comb begin
      push_data.addr  = req.position;
      push_data.value = req.operand_value;
      push_data.emit  = 1'b0;
      push_data.op    = OP_NONE;
      unique case (req.req_type)
         KIND_LOAD: begin
            push_data.op = (pos_ext < DepthLimit) ? OP_WRITE : OP_NONE;
         end
         KIND_NONZERO: begin
            push_data.op   = col_bad ? OP_BAD : OP_MAC;
            push_data.emit = req.row_last;
         end
         KIND_CLOSE: begin
            push_data.op   = OP_CLOSE;
            push_data.emit = 1'b1;
         end
         KIND_RESTART: begin
            push_data.op = OP_RESTART;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/csrspmv_queue.sv =====
// ----------------------------------------------------------------------------
// csrspmv_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module csrspmv_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  csrspmv_pkg::cmd_type       push_data,
   input  wire                        pop,
   output csrspmv_pkg::cmd_type       pop_data,
   output csrspmv_pkg::q_status_type  q_status
);

   import csrspmv_pkg::*;

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              do_push;
   logic              do_pop;

   assign q_status.count = count_ff;
   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign pop_data       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/csrspmv_back.sv =====
// ----------------------------------------------------------------------------
// csrspmv_back
// vector store, multiplier and saturating row accumulator
// ----------------------------------------------------------------------------
`default_nettype none

module csrspmv_back #(
   parameter int VECTOR_DEPTH = csrspmv_pkg::VECTOR_DEPTH_DEFAULT
) (
   input  wire                        clock,
   input  wire                        reset,
   input  csrspmv_pkg::cmd_type       pop_data,
   input  csrspmv_pkg::q_status_type  q_status,
   output logic                       pop,
   csrspmv_chan_if.source             rsp_if
);

   import csrspmv_pkg::*;

   localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
   localparam int SUM_W = PROD_W - FRAC_W + 1;

   logic [VALUE_W-1:0] store_mem [VECTOR_DEPTH];

   logic                       advance;
   logic [EXT_W-1:0]           addr_ext;
   logic [AW-1:0]              addr;

   // issue stage
   logic                       s1_valid_ff;
   cmd_op_type                 s1_op_ff;
   logic                       s1_emit_ff;
   logic signed [VALUE_W-1:0]  s1_value_ff;
   logic [VALUE_W-1:0]         rd_data_ff;

   // product stage
   logic                       s2_valid_ff;
   cmd_op_type                 s2_op_ff;
   logic                       s2_emit_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [PROD_W-1:0]   prod_in;

   // row state
   logic signed [VALUE_W-1:0]  acc_ff;
   logic signed [VALUE_W-1:0]  acc_in;
   logic                       sat_ff;
   logic                       sat_in;
   logic                       bad_ff;
   logic                       bad_in;
   logic [ROW_W-1:0]           row_ff;
   logic [ROW_W-1:0]           row_in;

   logic signed [SUM_W-1:0]    sum;
   logic signed [VALUE_W-1:0]  sum_sat;
   logic                       sum_ovf;
   logic                       upd;

   logic                       out_valid_ff;
   logic                       out_valid_in;
   rsp_payload_type            out_ff;
   rsp_payload_type            out_in;

   // whole back end holds while a result waits
   assign advance        = !out_valid_ff || rsp_if.ready;
   assign pop            = advance && !q_status.empty;
   assign addr_ext       = EXT_W'(pop_data.addr);
   assign addr           = addr_ext[AW-1:0];
   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_ff;

   always_ff @(posedge clock) begin
      if (pop && pop_data.op == OP_WRITE) begin
         store_mem[addr] <= pop_data.value;
      end
      if (advance) begin
         rd_data_ff <= store_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= pop;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   assign prod_in = PROD_W'(signed'(rd_data_ff)) * PROD_W'(s1_value_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff    <= pop_data.op;
         s1_emit_ff  <= pop_data.emit;
         s1_value_ff <= pop_data.value;
         s2_op_ff    <= s1_op_ff;
         s2_emit_ff  <= s1_emit_ff;
         prod_ff     <= prod_in;
      end
   end

   // floor of product / 2^16, then add with clamp to 32 bits
   assign sum = SUM_W'(acc_ff) + SUM_W'(signed'(prod_ff[PROD_W-1:FRAC_W]));
   assign sum_ovf = !((sum[SUM_W-1:VALUE_W-1] == '0) || (sum[SUM_W-1:VALUE_W-1] == '1));

   always_comb begin
      sum_sat = sum[VALUE_W-1:0];
      if (sum_ovf) begin
         sum_sat = sum[SUM_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
      end
   end

   assign upd = advance && s2_valid_ff;

   always_comb begin
      acc_in       = acc_ff;
      sat_in       = sat_ff;
      bad_in       = bad_ff;
      row_in       = row_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      if (upd) begin
         unique case (s2_op_ff)
            OP_MAC: begin
               acc_in = sum_sat;
               sat_in = sat_ff || sum_ovf;
            end
            OP_BAD: begin
               bad_in = 1'b1;
            end
            OP_RESTART: begin
               acc_in = '0;
               sat_in = 1'b0;
               bad_in = 1'b0;
               row_in = '0;
            end
            OP_NONE, OP_WRITE, OP_CLOSE: begin
               acc_in = acc_ff;
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
         if (s2_emit_ff) begin
            out_in.row_number = row_ff;
            out_in.row_sum    = acc_in;
            out_in.saturated  = sat_in;
            out_in.bad_column = bad_in;
            out_valid_in      = 1'b1;
            row_in            = row_ff + 1'b1;
            acc_in            = '0;
            sat_in            = 1'b0;
            bad_in            = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         sat_ff       <= 1'b0;
         bad_ff       <= 1'b0;
         row_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         sat_ff       <= sat_in;
         bad_ff       <= bad_in;
         row_ff       <= row_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/csr_spmv_row_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// csr_spmv_row_accumulator_unit
// csr sparse matrix times dense vector, q16.16 row sums with saturation flags
// ----------------------------------------------------------------------------
// path: closing request -> queue -> issue stage -> product stage -> response register
// throughput: one request per cycle when not stalled, set by the single store
//   read port and the one multiply plus saturating add per cycle in the back end
// reset: clears row sum, row flags, row counter, queue and pipeline valids;
//   vector length returns to 1024, vector store contents stay undefined
`default_nettype none

module csr_spmv_row_accumulator_unit #(
   parameter int VECTOR_DEPTH = csrspmv_pkg::VECTOR_DEPTH_DEFAULT
) (
   input  wire              clock,
   input  wire              reset,
   csrspmv_chan_if.sink     req_if,
   csrspmv_chan_if.source   rsp_if,
   csrspmv_chan_if.sink     csr_if
);

   import csrspmv_pkg::*;

   // front to queue
   logic         q_push;
   cmd_type      q_push_data;
   // queue to back
   logic         q_pop;
   cmd_type      q_pop_data;
   q_status_type q_status;

   // front: vector length register, column range check, command decode
   csrspmv_front #(
      .VECTOR_DEPTH (VECTOR_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .csr_if    (csr_if),
      .push      (q_push),
      .push_data (q_push_data),
      .q_status  (q_status)
   );

   // two-entry queue lets the front keep taking requests while a response stalls
   csrspmv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .q_status  (q_status)
   );

   // back: store access, multiply, accumulate, response register
   csrspmv_back #(
      .VECTOR_DEPTH (VECTOR_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_data (q_pop_data),
      .q_status (q_status),
      .pop      (q_pop),
      .rsp_if   (rsp_if)
   );

   // queue occupancy never passes its depth
   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      q_status.count <= QCNT_W'(QUEUE_DEPTH))
      else $error("command queue over depth");

   // back end only takes commands that are there
   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("pop from empty command queue");

   // a full queue with no pop keeps the request side stalled
   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      (q_status.full && !q_pop) |=> !req_if.ready)
      else $error("request taken while queue full");

endmodule

`default_nettype wire
